@@ rtl/tat_pkg.sv @@
// Shared constants, types and the resistance table of the thermistor converter.
package tat_pkg;

  // Converter and register widths
  localparam int ADC_BITS = 12;
  localparam int ADC_FULL = (1 << ADC_BITS) - 1;
  localparam int SER_W    = 16;
  localparam logic [SER_W-1:0] SERIES_RESET = 16'd14930;

  // Register indexes on the configuration port
  localparam logic REG_SERIES_OHMS = 1'b0;

  // Resistance path: R = (series*33*256*s + den/2) / den, den = 50*FULL - 33*s
  localparam int PROD_W   = SER_W + ADC_BITS;
  localparam int R_MULT   = 33 * 256;
  localparam int NUM_W    = PROD_W + $clog2(R_MULT + 1);
  localparam int DEN_BASE = 50 * ADC_FULL;
  localparam int DEN_W    = $clog2(DEN_BASE + 1);
  localparam int R_W      = 26;
  localparam logic [22:0] RES_MAX = 23'h7FFFFF;

  // Shared divider: remainder/divisor width, quotient width, step count width
  localparam int DV_W    = R_W;
  localparam int Q_W     = R_W;
  localparam int STEP_W  = $clog2(Q_W + 1);
  localparam int FRAC_BITS = 9;
  localparam int NUM2_W  = R_W + 9;

  // Table walk
  localparam int TABLE_LEN  = 151;
  localparam int ROM_GIVEN  = 151;
  localparam int IDX_W      = 8;
  localparam logic [IDX_W-1:0] TBL_TOP    = IDX_W'(TABLE_LEN - 2);
  localparam logic [IDX_W-1:0] LAST_RESET = IDX_W'(45);
  localparam int T_OFFSET   = 25;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DV_W-1:0]   rem_init;
    logic [Q_W-1:0]    dvd;
    logic [DV_W-1:0]   dvs;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

  // Descending resistance table, ohms*256 rounded, index i is (i-25) C
  localparam logic [R_W-1:0] NTC_ROM [0:ROM_GIVEN-1] = '{
    26'((13350000*128+25)/50), 26'((12567000*128+25)/50), 26'((11835000*128+25)/50),
    26'((11150000*128+25)/50), 26'((10508000*128+25)/50), 26'((9907700*128+25)/50),
    26'((9344700*128+25)/50), 26'((8817500*128+25)/50), 26'((8323000*128+25)/50),
    26'((7859100*128+25)/50), 26'((7423800*128+25)/50), 26'((7015300*128+25)/50),
    26'((6631600*128+25)/50), 26'((6271200*128+25)/50), 26'((5932500*128+25)/50),
    26'((5614200*128+25)/50), 26'((5314800*128+25)/50), 26'((5033100*128+25)/50),
    26'((4768000*128+25)/50), 26'((4518400*128+25)/50), 26'((4283400*128+25)/50),
    26'((4062000*128+25)/50), 26'((3853300*128+25)/50), 26'((3656600*128+25)/50),
    26'((3471000*128+25)/50), 26'((3296000*128+25)/50), 26'((3130800*128+25)/50),
    26'((2974900*128+25)/50), 26'((2827600*128+25)/50), 26'((2688500*128+25)/50),
    26'((2557000*128+25)/50), 26'((2432700*128+25)/50), 26'((2315200*128+25)/50),
    26'((2204100*128+25)/50), 26'((2098900*128+25)/50), 26'((1999300*128+25)/50),
    26'((1905100*128+25)/50), 26'((1815800*128+25)/50), 26'((1731200*128+25)/50),
    26'((1651100*128+25)/50), 26'((1575100*128+25)/50), 26'((1503100*128+25)/50),
    26'((1434700*128+25)/50), 26'((1369900*128+25)/50), 26'((1308300*128+25)/50),
    26'((1249900*128+25)/50), 26'((1194400*128+25)/50), 26'((1141700*128+25)/50),
    26'((1091600*128+25)/50), 26'((1044000*128+25)/50), 26'((1000000*128+25)/50),
    26'((955690*128+25)/50), 26'((914740*128+25)/50), 26'((875780*128+25)/50),
    26'((838690*128+25)/50), 26'((803380*128+25)/50), 26'((769750*128+25)/50),
    26'((737720*128+25)/50), 26'((707200*128+25)/50), 26'((678110*128+25)/50),
    26'((650380*128+25)/50), 26'((623930*128+25)/50), 26'((598710*128+25)/50),
    26'((574650*128+25)/50), 26'((551680*128+25)/50), 26'((529760*128+25)/50),
    26'((508830*128+25)/50), 26'((488840*128+25)/50), 26'((469740*128+25)/50),
    26'((451500*128+25)/50), 26'((434060*128+25)/50), 26'((417390*128+25)/50),
    26'((401450*128+25)/50), 26'((386210*128+25)/50), 26'((371620*128+25)/50),
    26'((358800*128+25)/50), 26'((344310*128+25)/50), 26'((331530*128+25)/50),
    26'((319290*128+25)/50), 26'((307560*128+25)/50), 26'((296330*128+25)/50),
    26'((285570*128+25)/50), 26'((275260*128+25)/50), 26'((265370*128+25)/50),
    26'((255890*128+25)/50), 26'((246800*128+25)/50), 26'((238080*128+25)/50),
    26'((229710*128+25)/50), 26'((221690*128+25)/50), 26'((213980*128+25)/50),
    26'((206580*128+25)/50), 26'((199480*128+25)/50), 26'((192660*128+25)/50),
    26'((186110*128+25)/50), 26'((179810*128+25)/50), 26'((173760*128+25)/50),
    26'((167940*128+25)/50), 26'((162350*128+25)/50), 26'((156970*128+25)/50),
    26'((151800*128+25)/50), 26'((147300*128+25)/50), 26'((142040*128+25)/50),
    26'((137440*128+25)/50), 26'((133010*128+25)/50), 26'((128740*128+25)/50),
    26'((124630*128+25)/50), 26'((120670*128+25)/50), 26'((116860*128+25)/50),
    26'((113190*128+25)/50), 26'((109650*128+25)/50), 26'((106250*128+25)/50),
    26'((102960*128+25)/50), 26'((99792*128+25)/50), 26'((96738*128+25)/50),
    26'((93792*128+25)/50), 26'((90950*128+25)/50), 26'((88208*128+25)/50),
    26'((85563*128+25)/50), 26'((83010*128+25)/50), 26'((80546*128+25)/50),
    26'((78167*128+25)/50), 26'((75870*128+25)/50), 26'((73652*128+25)/50),
    26'((71509*128+25)/50), 26'((69440*128+25)/50), 26'((67440*128+25)/50),
    26'((65507*128+25)/50), 26'((63640*128+25)/50), 26'((61840*128+25)/50),
    26'((60089*128+25)/50), 26'((58401*128+25)/50), 26'((56769*128+25)/50),
    26'((55190*128+25)/50), 26'((53663*128+25)/50), 26'((52185*128+25)/50),
    26'((50755*128+25)/50), 26'((49371*128+25)/50), 26'((48032*128+25)/50),
    26'((46735*128+25)/50), 26'((45479*128+25)/50), 26'((44263*128+25)/50),
    26'((43085*128+25)/50), 26'((41944*128+25)/50), 26'((40838*128+25)/50),
    26'((39767*128+25)/50), 26'((38729*128+25)/50), 26'((37723*128+25)/50),
    26'((36748*128+25)/50), 26'((35803*128+25)/50), 26'((34886*128+25)/50),
    26'((33997*128+25)/50)
  };

  // Table read; entries past the given ones read as zero
  function automatic logic [R_W-1:0] rom_read(input logic [IDX_W-1:0] idx);
    logic [R_W-1:0] val;
    val = '0;
    if (int'(idx) < ROM_GIVEN) val = NTC_ROM[idx];
    return val;
  endfunction

endpackage

@@ rtl/tat_div.sv @@
// Iterative radix-2 restoring divider shared by the resistance and interpolation steps.
module tat_div (
  input  logic              clk,
  input  logic              rst,
  input  tat_pkg::div_req_t req,
  output tat_pkg::div_rsp_t rsp
);

  logic [tat_pkg::DV_W-1:0]   rem;
  logic [tat_pkg::Q_W-1:0]    sh;
  logic [tat_pkg::Q_W-1:0]    quot;
  logic [tat_pkg::DV_W-1:0]   dvs;
  logic [tat_pkg::STEP_W-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [tat_pkg::DV_W:0]     trial;
  logic                       ge;
  logic [tat_pkg::DV_W:0]     diff;

  // One quotient bit per cycle: shift in next dividend bit, compare, subtract
  assign trial = {rem, sh[tat_pkg::Q_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == tat_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.rem_init;
      sh   <= req.dvd;
      dvs  <= req.dvs;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[tat_pkg::DV_W-1:0] : trial[tat_pkg::DV_W-1:0];
      sh   <= {sh[tat_pkg::Q_W-2:0], 1'b0};
      quot <= {quot[tat_pkg::Q_W-2:0], ge};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

@@ rtl/thermistor_adc_to_temperature.sv @@
// Top level: register port, walk sequencer, result register of the thermistor converter.
//
// Converts one 12-bit divider reading into thermistor resistance (ohms*256) and an
// interpolated temperature in 1/256 C. The table walk starts from the index the
// previous word ended on. The shared radix-2 divider runs 26 iterations for the
// resistance and 9 for the interpolation fraction; the walk reads one table entry
// per cycle. in_ready is high only between words; a finished result waits in the
// output register while the next word is taken. series_ohms sits at byte address 0
// and should be written while idle.
module thermistor_adc_to_temperature (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        adc_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] temperature,
  output logic               valid_res,
  output logic [22:0]        resistance,
  output logic [7:0]         bracket_index
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_DV1  = 4'd2;
  localparam logic [3:0] S_DW1  = 4'd3;
  localparam logic [3:0] S_UP   = 4'd4;
  localparam logic [3:0] S_DN   = 4'd5;
  localparam logic [3:0] S_CKL  = 4'd6;
  localparam logic [3:0] S_DV2  = 4'd7;
  localparam logic [3:0] S_DW2  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]                     state;
  logic [tat_pkg::SER_W-1:0]      series_ohms;
  logic [tat_pkg::IDX_W-1:0]      last_index;
  logic [tat_pkg::ADC_BITS-1:0]   samp;
  logic [tat_pkg::PROD_W-1:0]     prod;
  logic [tat_pkg::DEN_W-1:0]      den;
  logic [tat_pkg::DEN_W-1:0]      den_calc;
  logic [tat_pkg::NUM_W-1:0]      numer;
  logic [tat_pkg::R_W-1:0]        r_q;
  logic [tat_pkg::IDX_W-1:0]      idx;
  logic [tat_pkg::IDX_W-1:0]      rom_addr;
  logic [tat_pkg::R_W-1:0]        rom_q;
  logic [tat_pkg::R_W-1:0]        hi_q;
  logic [tat_pkg::R_W-1:0]        lo_q;
  logic                           ok_q;
  logic [tat_pkg::R_W-1:0]        dlt;
  logic [tat_pkg::NUM2_W-1:0]     numer2;
  logic [tat_pkg::FRAC_BITS-1:0]  frac_q;
  logic signed [17:0]             t_full;
  logic signed [15:0]             t_sat;
  logic                           cfg_wr;
  tat_pkg::div_req_t              div_req;
  tat_pkg::div_rsp_t              div_rsp;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == tat_pkg::REG_SERIES_OHMS);
  assign prdata = (paddr[2] == tat_pkg::REG_SERIES_OHMS) ?
                  {{(32-tat_pkg::SER_W){1'b0}}, series_ohms} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_ohms <= tat_pkg::SERIES_RESET;
    end else if (cfg_wr) begin
      series_ohms <= pwdata[tat_pkg::SER_W-1:0];
    end
  end

  // Divider operands
  assign den_calc = tat_pkg::DEN_W'(tat_pkg::DEN_BASE)
                  - ({samp, 5'b0} + tat_pkg::DEN_W'(samp));
  assign numer    = tat_pkg::NUM_W'(prod) * tat_pkg::NUM_W'(tat_pkg::R_MULT)
                  + tat_pkg::NUM_W'(den >> 1);
  assign dlt      = hi_q - lo_q;
  assign numer2   = {1'b0, hi_q - r_q, 8'h00} + tat_pkg::NUM2_W'(dlt >> 1);

  always_comb begin
    div_req          = '0;
    div_req.start    = (state == S_DV1) || (state == S_DV2);
    if (state == S_DV2) begin
      div_req.steps    = tat_pkg::STEP_W'(tat_pkg::FRAC_BITS);
      div_req.rem_init = numer2[tat_pkg::NUM2_W-1:tat_pkg::FRAC_BITS];
      div_req.dvd      = {numer2[tat_pkg::FRAC_BITS-1:0],
                          {(tat_pkg::Q_W-tat_pkg::FRAC_BITS){1'b0}}};
      div_req.dvs      = dlt;
    end else begin
      div_req.steps    = tat_pkg::STEP_W'(tat_pkg::Q_W);
      div_req.rem_init = tat_pkg::DV_W'(numer[tat_pkg::NUM_W-1:tat_pkg::Q_W]);
      div_req.dvd      = numer[tat_pkg::Q_W-1:0];
      div_req.dvs      = tat_pkg::DV_W'(den);
    end
  end

  tat_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Table read port: next entry while walking up and for the low bracket
  assign rom_addr = ((state == S_UP) || (state == S_CKL)) ? idx + 1'b1 : idx;
  assign rom_q    = tat_pkg::rom_read(rom_addr);

  // Temperature from index and fraction, saturated on the high side
  assign t_full = $signed({2'b00, idx, 8'h00}) - 18'(tat_pkg::T_OFFSET * 256)
                + $signed({9'b0, frac_q});
  assign t_sat  = (t_full > 18'sd32767) ? 16'sh7FFF : t_full[15:0];

  assign in_ready = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      last_index <= tat_pkg::LAST_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_FIN && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) state <= S_MUL;
        S_MUL:  state <= S_DV1;
        S_DV1:  state <= S_DW1;
        S_DW1:  if (div_rsp.done) state <= S_UP;
        S_UP: begin
          if (!(idx < tat_pkg::TBL_TOP && rom_q >= r_q)) state <= S_DN;
        end
        S_DN: begin
          if (!(idx != '0 && rom_q < r_q)) state <= S_CKL;
        end
        S_CKL: begin
          last_index <= idx;
          state      <= (hi_q >= r_q && rom_q < r_q) ? S_DV2 : S_FIN;
        end
        S_DV2:  state <= S_DW2;
        S_DW2:  if (div_rsp.done) state <= S_FIN;
        S_FIN: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        samp   <= adc_sample[tat_pkg::ADC_BITS-1:0];
        frac_q <= '0;
      end
      S_MUL: begin
        prod <= tat_pkg::PROD_W'(series_ohms) * tat_pkg::PROD_W'(samp);
        den  <= den_calc;
      end
      S_DW1: begin
        r_q <= div_rsp.quot;
        idx <= (last_index > tat_pkg::TBL_TOP) ? tat_pkg::TBL_TOP : last_index;
      end
      S_UP: begin
        if (idx < tat_pkg::TBL_TOP && rom_q >= r_q) idx <= idx + 1'b1;
      end
      S_DN: begin
        hi_q <= rom_q;
        if (idx != '0 && rom_q < r_q) idx <= idx - 1'b1;
      end
      S_CKL: begin
        lo_q <= rom_q;
        ok_q <= hi_q >= r_q && rom_q < r_q;
      end
      S_DW2: frac_q <= div_rsp.quot[tat_pkg::FRAC_BITS-1:0];
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || out_ready)) begin
      temperature   <= ok_q ? t_sat : 16'sh0000;
      valid_res     <= ok_q;
      resistance    <= (r_q > tat_pkg::R_W'(tat_pkg::RES_MAX)) ? tat_pkg::RES_MAX : r_q[22:0];
      bracket_index <= idx;
    end
  end

  // Checks
  a_start_mul: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_MUL)
    else $error("accepted word did not start the multiply step");

  a_bracket: assert property (@(posedge clk) disable iff (rst)
    state == S_DV2 |-> hi_q >= r_q && lo_q < r_q)
    else $error("interpolation started without a bracket");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    last_index <= tat_pkg::TBL_TOP || last_index == tat_pkg::LAST_RESET)
    else $error("stored walk index out of range");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DW1 || state == S_DW2)
    else $error("divider finished outside a wait state");

  a_frac: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> frac_q <= tat_pkg::FRAC_BITS'(256))
    else $error("interpolation fraction above one degree");

endmodule

@@ dv/tb_thermistor_adc_to_temperature.sv @@
// Testbench for the thermistor converter: table-driven and random words checked against a predictor.
module tb_thermistor_adc_to_temperature;

  localparam int ADC_MAX        = (1 << tat_pkg::ADC_BITS) - 1;
  localparam int NTC_POINTS     = 151;
  localparam int WALK_TOP       = NTC_POINTS - 2;
  localparam int DEG_OFFSET     = 25;
  localparam int SERIES_DEFAULT = 14930;
  localparam int WALK_DEFAULT   = 45;
  localparam longint unsigned RES_CEIL = 64'd8388607;

  // Register byte addresses
  localparam logic [2:0] ADDR_SERIES = {tat_pkg::REG_SERIES_OHMS, 2'b00};
  localparam logic       REG_SPARE   = 1'b1;
  localparam logic [2:0] ADDR_SPARE  = {REG_SPARE, 2'b00};

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_WORDS   = 210;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 1500000;

  // Thermistor curve in 0.01 ohm, one entry per degree from -25 C
  localparam int unsigned NTC_CENTIOHM [0:NTC_POINTS-1] = '{
    13350000, 12567000, 11835000, 11150000, 10508000, 9907700, 9344700, 8817500, 8323000,
    7859100, 7423800, 7015300, 6631600, 6271200, 5932500, 5614200, 5314800, 5033100,
    4768000, 4518400, 4283400, 4062000, 3853300, 3656600, 3471000, 3296000, 3130800,
    2974900, 2827600, 2688500, 2557000, 2432700, 2315200, 2204100, 2098900, 1999300,
    1905100, 1815800, 1731200, 1651100, 1575100, 1503100, 1434700, 1369900, 1308300,
    1249900, 1194400, 1141700, 1091600, 1044000, 1000000, 955690, 914740, 875780,
    838690, 803380, 769750, 737720, 707200, 678110, 650380, 623930, 598710,
    574650, 551680, 529760, 508830, 488840, 469740, 451500, 434060, 417390,
    401450, 386210, 371620, 358800, 344310, 331530, 319290, 307560, 296330,
    285570, 275260, 265370, 255890, 246800, 238080, 229710, 221690, 213980,
    206580, 199480, 192660, 186110, 179810, 173760, 167940, 162350, 156970,
    151800, 147300, 142040, 137440, 133010, 128740, 124630, 120670, 116860,
    113190, 109650, 106250, 102960, 99792, 96738, 93792, 90950, 88208,
    85563, 83010, 80546, 78167, 75870, 73652, 71509, 69440, 67440,
    65507, 63640, 61840, 60089, 58401, 56769, 55190, 53663, 52185,
    50755, 49371, 48032, 46735, 45479, 44263, 43085, 41944, 40838,
    39767, 38729, 37723, 36748, 35803, 34886, 33997
  };

  typedef struct packed {
    logic [15:0] temp;
    logic        ok;
    logic [22:0] res;
    logic [7:0]  idx;
  } reading_t;

  typedef struct packed {
    logic [15:0] series;
    logic [11:0] sample;
    logic        typed;
  } probe_t;

  // Zero reading: R is 0, the walk runs to the top and finds no bracket
  localparam reading_t BELOW_TABLE = '{16'd0, 1'b0, 23'd0, 8'd149};

  // Directed words; a series change drains the block and rewrites the register
  probe_t directed_rows [0:21] = '{
    '{16'd14930, 12'd2048, 1'b0}, '{16'd14930, 12'd0,    1'b1},
    '{16'd14930, 12'd4095, 1'b0}, '{16'd14930, 12'd1,    1'b0},
    '{16'd14930, 12'd4094, 1'b0}, '{16'd14930, 12'd1000, 1'b0},
    '{16'd14930, 12'd3000, 1'b0}, '{16'd14930, 12'd2,    1'b0},
    '{16'd14930, 12'd2730, 1'b0}, '{16'd65535, 12'd4095, 1'b0},
    '{16'd65535, 12'd0,    1'b1}, '{16'd65535, 12'd2048, 1'b0},
    '{16'd65535, 12'd3500, 1'b0}, '{16'd65535, 12'd1,    1'b0},
    '{16'd1000,  12'd4095, 1'b0}, '{16'd1000,  12'd0,    1'b1},
    '{16'd1000,  12'd2047, 1'b0}, '{16'd1000,  12'd3800, 1'b0},
    '{16'd1000,  12'd100,  1'b0}, '{16'd14930, 12'd2500, 1'b0},
    '{16'd14930, 12'd1365, 1'b0}, '{16'd14930, 12'd4095, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [11:0]        adc_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] temperature;
  logic               valid_res;
  logic [22:0]        resistance;
  logic [7:0]         bracket_index;

  // Predictor state
  logic [15:0] series_cfg = 16'(SERIES_DEFAULT);
  int          walk_from = WALK_DEFAULT;
  reading_t    readings_due [$];
  int          mismatches = 0;
  int          readings_taken = 0;
  int          cycle_count = 0;

  thermistor_adc_to_temperature dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .adc_sample(adc_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .temperature(temperature), .valid_res(valid_res),
    .resistance(resistance), .bracket_index(bracket_index)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Curve entry in ohms*256, rounded; zero past the end
  function automatic longint unsigned ntc_ohm256(input int i);
    longint unsigned v;
    v = 0;
    if (i < NTC_POINTS) v = (longint'(NTC_CENTIOHM[i]) * 256 + 50) / 100;
    return v;
  endfunction

  // Resistance, table walk from the last index, then linear interpolation
  function automatic reading_t convert_sample(input logic [11:0] s);
    longint unsigned sv, den, r, hi, lo, d, frac;
    int       i, t;
    reading_t o;
    sv  = longint'(s);
    den = 50 * longint'(ADC_MAX) - 33 * sv;
    r   = (longint'(series_cfg) * 33 * 256 * sv + den / 2) / den;
    i = walk_from;
    if (i > WALK_TOP) i = WALK_TOP;
    while (i < WALK_TOP && ntc_ohm256(i + 1) >= r) i++;
    while (i > 0 && ntc_ohm256(i) < r) i--;
    walk_from = i;
    hi = ntc_ohm256(i);
    lo = ntc_ohm256(i + 1);
    o.ok = (hi >= r) && (lo < r);
    t = 0;
    if (o.ok) begin
      d    = hi - lo;
      frac = ((hi - r) * 256 + d / 2) / d;
      t    = (i - DEG_OFFSET) * 256 + int'(frac);
      if (t > 32767) t = 32767;
    end
    o.temp = t[15:0];
    o.res  = (r > RES_CEIL) ? RES_CEIL[22:0] : r[22:0];
    o.idx  = i[7:0];
    return o;
  endfunction

  function automatic logic [11:0] pick_sample(input logic [11:0] prev);
    int roll, v;
    roll = $urandom_range(0, 99);
    if (roll < 55) v = $urandom_range(0, ADC_MAX);
    else if (roll < 70) v = $urandom_range(0, 255);
    else if (roll < 85) v = $urandom_range(ADC_MAX - 255, ADC_MAX);
    else begin
      // nearby reading: short walk from the kept index
      v = int'(prev) + $urandom_range(0, 40) - 20;
      if (v < 0) v = 0;
      if (v > ADC_MAX) v = ADC_MAX;
    end
    return v[11:0];
  endfunction

  task automatic check_field(input string label, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  // Register write: setup phase, access phase held until pready, then the bus goes idle
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    logic done;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    if (addr == ADDR_SERIES) series_cfg = data[15:0];
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic series_readback();
    logic done;
    logic [31:0] got;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= ADDR_SERIES;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      got  = prdata;
      @(posedge clk);
    end while (!done);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    check_field("series_ohms readback", longint'({16'd0, series_cfg}), longint'(got));
  endtask

  // Drain the block, let it settle, then rewrite the series resistor and read it back
  task automatic set_series(input logic [15:0] val);
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(ADDR_SERIES, {16'($urandom), val});
    series_readback();
  endtask

  // Offer one word; predict at the accepting edge, then drop in_valid for the requested gap
  task automatic offer_word(input logic [11:0] s, input int gap, input bit use_typed,
                            input reading_t typed_want);
    logic     taken;
    reading_t pred;
    in_valid <= 1'b1;
    adc_sample <= s;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    pred = convert_sample(s);
    readings_due.push_back(use_typed ? typed_want : pred);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result checker; handshake values are stable at the falling edge
  always @(negedge clk) begin
    reading_t w;
    if (!rst && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected word: temperature %0d, valid_res %0d, resistance %0d, index %0d",
                 $time, temperature, valid_res, resistance, bracket_index);
        mismatches++;
      end else begin
        w = readings_due.pop_front();
        check_field("temperature", longint'($signed(w.temp)), longint'(temperature));
        check_field("valid_res", longint'(w.ok), longint'(valid_res));
        check_field("resistance", longint'(w.res), longint'(resistance));
        check_field("bracket_index", longint'(w.idx), longint'(bracket_index));
      end
      readings_taken++;
    end
  end

  // Receiver: changing stall patterns, plus one long hold-off to back up the input
  initial begin
    int  mode, span;
    bit  held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && readings_taken >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = (mode == 3) ? $urandom_range(1, 40) : $urandom_range(16, 160);
        repeat (span) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 4) == 0);
            default: out_ready <= 1'b0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d words outstanding",
               $time, cycle_count, readings_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int          r, ph, n, gap, burst_left;
    logic [11:0] s;
    logic [15:0] ser;
    s = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value, and a write to an unused address leaves it alone
    series_readback();
    reg_write(ADDR_SPARE, 32'hFFFF_0BAD);
    series_readback();

    for (r = 0; r < $size(directed_rows); r++) begin
      if (directed_rows[r].series != series_cfg) set_series(directed_rows[r].series);
      offer_word(directed_rows[r].sample, $urandom_range(0, 3), directed_rows[r].typed,
                 BELOW_TABLE);
    end

    // random phases, extremes of the series resistor first
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: ser = 16'd65535;
        1: ser = 16'd1000;
        4: ser = 16'(SERIES_DEFAULT);
        default: ser = 16'($urandom_range(1000, 65535));
      endcase
      set_series(ser);
      burst_left = $urandom_range(1, 30);
      for (n = 0; n < PHASE_WORDS; n++) begin
        s = pick_sample(s);
        burst_left--;
        if (n == PHASE_WORDS - 1) gap = 1;
        else if (burst_left == 0) begin
          gap = $urandom_range(1, 40);
          burst_left = $urandom_range(1, 30);
        end else gap = 0;
        offer_word(s, gap, 1'b0, BELOW_TABLE);
      end
    end

    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
